[sv/pvaw_pkg.sv]
// Shared types, constants and arithmetic helpers for the velocity-form PID block.
// Holds the microcode table that the controller steps through.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pvaw_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int STEP_W = 5;
  localparam int ADDR_W = 5;

  typedef logic signed [DATA_W-1:0] word_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_PROP_GAIN       = 3'd0;
  localparam logic [2:0] REG_SETPOINT_WEIGHT = 3'd1;
  localparam logic [2:0] REG_INTEGRAL_COEF   = 3'd2;
  localparam logic [2:0] REG_DERIV_POLE      = 3'd3;
  localparam logic [2:0] REG_DERIV_GAIN      = 3'd4;
  localparam logic [2:0] REG_WINDUP_COEF     = 3'd5;
  localparam logic [2:0] REG_INV_PLANT_GAIN  = 3'd6;
  localparam logic [2:0] REG_OUTPUT_MAX      = 3'd7;

  localparam word_t RST_ONE        = word_t'(1) << FRAC_W;
  localparam logic [DATA_W-2:0] RST_OUTPUT_MAX = 31'd268369920;

  // Operand sources inside the datapath
  typedef enum logic [4:0] {
    SRC_ZERO  = 5'd0,
    SRC_FM    = 5'd1,
    SRC_ACC   = 5'd2,
    SRC_TMP   = 5'd3,
    SRC_AUX   = 5'd4,
    SRC_REF   = 5'd5,
    SRC_DIST  = 5'd6,
    SRC_MNOW  = 5'd7,
    SRC_MPREV = 5'd8,
    SRC_PPREV = 5'd9,
    SRC_INOW  = 5'd10,
    SRC_IPREV = 5'd11,
    SRC_DPREV = 5'd12,
    SRC_UPREV = 5'd13,
    SRC_CLAMP = 5'd14,
    SRC_D1    = 5'd15,
    SRC_U1    = 5'd16
  } src_t;

  // Coefficient operand of the multiplier
  typedef enum logic [2:0] {
    COEF_K  = 3'd0,
    COEF_B  = 3'd1,
    COEF_IC = 3'd2,
    COEF_AD = 3'd3,
    COEF_BD = 3'd4,
    COEF_WC = 3'd5,
    COEF_IG = 3'd6
  } coef_t;

  // Destination of the saturating adder
  typedef enum logic [2:0] {
    DST_NONE  = 3'd0,
    DST_ACC   = 3'd1,
    DST_TMP   = 3'd2,
    DST_AUX   = 3'd3,
    DST_D1    = 3'd4,
    DST_U1    = 3'd5,
    DST_INTEG = 3'd6
  } dst_t;

  // One microcode word
  typedef struct packed {
    coef_t mul_coef;
    src_t  mul_src;
    src_t  alu_a;
    src_t  alu_b;
    logic  alu_sub;
    dst_t  alu_dst;
    logic  cap_p1;     // new proportional term <- rounded product
    logic  clamp;      // drive <- product with anti-windup clamp
    logic  take_v;     // drive <- product, no clamp
    logic  commit_fb;  // shift P, D, u into their previous-sample registers
    logic  last;       // final step, loads the output word
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    cmd_t cmd;
    logic exec;
    logic load_in;
  } dp_ctl_t;

  typedef struct packed {
    word_t             prop_gain;
    word_t             setpoint_weight;
    word_t             integral_coef;
    word_t             deriv_pole;
    word_t             deriv_gain;
    word_t             windup_coef;
    word_t             inv_plant_gain;
    logic [DATA_W-2:0] output_max;
  } cfg_t;

  // All data operands the datapath can select
  typedef struct packed {
    word_t fm;
    word_t acc;
    word_t tmp;
    word_t aux;
    word_t refv;
    word_t disturb;
    word_t mnow;
    word_t mprev;
    word_t pprev;
    word_t inow;
    word_t iprev;
    word_t dprev;
    word_t uprev;
    word_t clamp;
    word_t d1;
    word_t u1;
  } srcs_t;

  // Saturate a one-bit-grown value to the word range
  function automatic word_t sat_wide(input logic signed [DATA_W:0] v);
    word_t r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Round an exact product half away from zero, drop the fraction, saturate
  function automatic word_t fmul_fin(input logic signed [PROD_W-1:0] p, input logic neg);
    logic [PROD_W-1:0]        m;
    logic [PROD_W-1:0]        r;
    logic [PROD_W-FRAC_W-1:0] res;
    logic [DATA_W:0]          lim;
    logic [DATA_W:0]          mres;
    logic [DATA_W:0]          nres;
    m   = neg ? PROD_W'(-p) : PROD_W'(p);
    r   = m + (PROD_W'(1) << (FRAC_W - 1));
    res = r[PROD_W-1:FRAC_W];
    lim = (DATA_W+1)'(1) << (DATA_W - 1);
    if (!neg) begin
      lim = lim - (DATA_W+1)'(1);
    end
    if (res > (PROD_W-FRAC_W)'(lim)) begin
      mres = lim;
    end else begin
      mres = res[DATA_W:0];
    end
    nres = -mres;
    return neg ? nres[DATA_W-1:0] : mres[DATA_W-1:0];
  endfunction

  function automatic word_t pick(input src_t s, input srcs_t v);
    word_t r;
    case (s)
      SRC_ZERO:  r = '0;
      SRC_FM:    r = v.fm;
      SRC_ACC:   r = v.acc;
      SRC_TMP:   r = v.tmp;
      SRC_AUX:   r = v.aux;
      SRC_REF:   r = v.refv;
      SRC_DIST:  r = v.disturb;
      SRC_MNOW:  r = v.mnow;
      SRC_MPREV: r = v.mprev;
      SRC_PPREV: r = v.pprev;
      SRC_INOW:  r = v.inow;
      SRC_IPREV: r = v.iprev;
      SRC_DPREV: r = v.dprev;
      SRC_UPREV: r = v.uprev;
      SRC_CLAMP: r = v.clamp;
      SRC_D1:    r = v.d1;
      SRC_U1:    r = v.u1;
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic word_t pick_coef(input coef_t c, input cfg_t g);
    word_t r;
    case (c)
      COEF_K:  r = g.prop_gain;
      COEF_B:  r = g.setpoint_weight;
      COEF_IC: r = g.integral_coef;
      COEF_AD: r = g.deriv_pole;
      COEF_BD: r = g.deriv_gain;
      COEF_WC: r = g.windup_coef;
      COEF_IG: r = g.inv_plant_gain;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Microcode. A product passes the product and rounding registers, then reads as SRC_FM.
  function automatic cmd_t ucode(input logic fb, input logic [STEP_W-1:0] step);
    cmd_t c;
    c.mul_coef  = COEF_WC;
    c.mul_src   = SRC_CLAMP;
    c.alu_a     = SRC_ZERO;
    c.alu_b     = SRC_ZERO;
    c.alu_sub   = 1'b0;
    c.alu_dst   = DST_NONE;
    c.cap_p1    = 1'b0;
    c.clamp     = 1'b0;
    c.take_v    = 1'b0;
    c.commit_fb = 1'b0;
    c.last      = 1'b0;
    if (fb) begin
      case (step)
        5'd0: begin
          // b*ref; dm = y - yprev
          c.mul_coef = COEF_B;  c.mul_src = SRC_REF;
          c.alu_a = SRC_MNOW;   c.alu_b = SRC_MPREV; c.alu_sub = 1'b1; c.alu_dst = DST_ACC;
        end
        5'd1: begin
          // bd*dm; q = ref - y
          c.mul_coef = COEF_BD; c.mul_src = SRC_ACC;
          c.alu_a = SRC_REF;    c.alu_b = SRC_MNOW;  c.alu_sub = 1'b1; c.alu_dst = DST_TMP;
        end
        5'd2: begin
          // ic*q; e = b*ref - y
          c.mul_coef = COEF_IC; c.mul_src = SRC_TMP;
          c.alu_a = SRC_FM;     c.alu_b = SRC_MNOW;  c.alu_sub = 1'b1; c.alu_dst = DST_ACC;
        end
        5'd3: begin
          // k*e; keep bd*dm
          c.mul_coef = COEF_K;  c.mul_src = SRC_ACC;
          c.alu_a = SRC_FM;     c.alu_dst = DST_AUX;
        end
        5'd4: begin
          // ad*Dprev; partial integral
          c.mul_coef = COEF_AD; c.mul_src = SRC_DPREV;
          c.alu_a = SRC_FM;     c.alu_b = SRC_INOW;  c.alu_dst = DST_TMP;
        end
        5'd5: begin
          c.cap_p1 = 1'b1;
          c.alu_a = SRC_FM;     c.alu_b = SRC_PPREV; c.alu_sub = 1'b1; c.alu_dst = DST_ACC;
        end
        5'd6: begin
          c.alu_a = SRC_FM;     c.alu_b = SRC_AUX;   c.alu_sub = 1'b1; c.alu_dst = DST_D1;
        end
        5'd7: begin
          c.alu_a = SRC_INOW;   c.alu_b = SRC_IPREV; c.alu_sub = 1'b1; c.alu_dst = DST_AUX;
        end
        5'd8: begin
          c.alu_a = SRC_ACC;    c.alu_b = SRC_AUX;   c.alu_dst = DST_ACC;
        end
        5'd9: begin
          c.alu_a = SRC_D1;     c.alu_b = SRC_DPREV; c.alu_sub = 1'b1; c.alu_dst = DST_AUX;
        end
        5'd10: begin
          c.alu_a = SRC_ACC;    c.alu_b = SRC_AUX;   c.alu_dst = DST_ACC;
        end
        5'd11: begin
          c.alu_a = SRC_ACC;    c.alu_b = SRC_UPREV; c.alu_dst = DST_U1;
        end
        5'd12: begin
          c.alu_a = SRC_U1;     c.alu_b = SRC_REF;   c.alu_dst = DST_ACC;
        end
        5'd13: begin
          c.alu_a = SRC_ACC;    c.alu_b = SRC_DIST;  c.alu_sub = 1'b1; c.alu_dst = DST_ACC;
        end
        5'd14: begin
          c.mul_coef = COEF_IG; c.mul_src = SRC_ACC;
        end
        5'd15: begin
          c.mul_coef = COEF_IG; c.mul_src = SRC_ACC;
        end
        5'd16: begin
          c.clamp = 1'b1;
        end
        5'd17, 5'd18: begin
          // windup product uses the fresh clamp error (default multiplier operands)
        end
        5'd19: begin
          c.alu_a = SRC_TMP;    c.alu_b = SRC_FM;    c.alu_dst = DST_INTEG;
          c.commit_fb = 1'b1;
          c.last = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      case (step)
        5'd0: begin
          c.alu_a = SRC_REF;    c.alu_b = SRC_MNOW;  c.alu_sub = 1'b1; c.alu_dst = DST_TMP;
        end
        5'd1: begin
          c.mul_coef = COEF_IC; c.mul_src = SRC_TMP;
          c.alu_a = SRC_REF;    c.alu_b = SRC_DIST;  c.alu_sub = 1'b1; c.alu_dst = DST_ACC;
        end
        5'd2: begin
          c.mul_coef = COEF_IG; c.mul_src = SRC_ACC;
        end
        5'd3: begin
          c.alu_a = SRC_FM;     c.alu_b = SRC_INOW;  c.alu_dst = DST_TMP;
        end
        5'd4: begin
          c.take_v = 1'b1;
        end
        5'd5: begin
          c.alu_a = SRC_TMP;    c.alu_b = SRC_FM;    c.alu_dst = DST_INTEG;
          c.last = 1'b1;
        end
        default: begin
        end
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/pid_velocity_antiwindup.sv]
// Velocity-form PID with set-point weighting, filtered derivative, feed-forward
// and back-calculation anti-windup, all in saturating signed Q16.16.
// Channels: a sample word (reference, measured, disturbance, feedback_on,
// antiwindup_on) goes in on sample_valid / sample_stall; one drive word per
// sample comes out on drive_valid / drive_stall. A word moves at a clock edge
// where valid is high and stall is low. Coefficients sit behind the APB port,
// one 32-bit register every 4 bytes; write them only while the block is idle.
// Timing: a sample is taken, then the sequencer runs 20 steps with feedback on
// and 6 with feedback off; the drive word is valid on the cycle after the last
// step. Samples go one at a time: a new sample is taken only once the last one
// is through its steps, as all terms pass through the one shared multiplier and
// saturating adder.
// A finished word waits in the output register; the next sample is taken and
// worked on meanwhile, and only its final step waits while drive_stall holds
// the previous word. Reset (rst, synchronous) clears the loop state to zero,
// loads the coefficient defaults and empties the output register.
// Depends on pvaw_pkg, pvaw_regs, pvaw_ctrl and pvaw_dp.
`timescale 1ns / 1ps
`default_nettype none

module pid_velocity_antiwindup (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample channel
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire logic signed [pvaw_pkg::DATA_W-1:0]  reference,
  input  wire logic signed [pvaw_pkg::DATA_W-1:0]  measured,
  input  wire logic signed [pvaw_pkg::DATA_W-1:0]  disturbance,
  input  wire logic                                feedback_on,
  input  wire logic                                antiwindup_on,
  // drive channel
  output logic                                     drive_valid,
  input  wire logic                                drive_stall,
  output logic signed [pvaw_pkg::DATA_W-1:0]       drive,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pvaw_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [pvaw_pkg::DATA_W-1:0]         pwdata,
  output logic      [pvaw_pkg::DATA_W-1:0]         prdata,
  output logic                                     pready
);

  pvaw_pkg::cfg_t    cfg;
  pvaw_pkg::dp_ctl_t ctl;

  pvaw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pvaw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .feedback_on  (feedback_on),
    .drive_valid  (drive_valid),
    .drive_stall  (drive_stall),
    .ctl          (ctl)
  );

  pvaw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cfg           (cfg),
    .reference     (reference),
    .measured      (measured),
    .disturbance   (disturbance),
    .feedback_on   (feedback_on),
    .antiwindup_on (antiwindup_on),
    .drive         (drive)
  );

endmodule

`default_nettype wire

[sv/pvaw_regs.sv]
// Configuration register bank with an APB-style access port.
// Depends on pvaw_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module pvaw_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pvaw_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pvaw_pkg::DATA_W-1:0]  pwdata,
  output logic      [pvaw_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output pvaw_pkg::cfg_t                    cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[pvaw_pkg::ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain       <= pvaw_pkg::RST_ONE;
      cfg.setpoint_weight <= pvaw_pkg::RST_ONE;
      cfg.integral_coef   <= '0;
      cfg.deriv_pole      <= '0;
      cfg.deriv_gain      <= '0;
      cfg.windup_coef     <= '0;
      cfg.inv_plant_gain  <= pvaw_pkg::RST_ONE;
      cfg.output_max      <= pvaw_pkg::RST_OUTPUT_MAX;
    end else if (wr_en) begin
      case (idx)
        pvaw_pkg::REG_PROP_GAIN:       cfg.prop_gain       <= pwdata;
        pvaw_pkg::REG_SETPOINT_WEIGHT: cfg.setpoint_weight <= pwdata;
        pvaw_pkg::REG_INTEGRAL_COEF:   cfg.integral_coef   <= pwdata;
        pvaw_pkg::REG_DERIV_POLE:      cfg.deriv_pole      <= pwdata;
        pvaw_pkg::REG_DERIV_GAIN:      cfg.deriv_gain      <= pwdata;
        pvaw_pkg::REG_WINDUP_COEF:     cfg.windup_coef     <= pwdata;
        pvaw_pkg::REG_INV_PLANT_GAIN:  cfg.inv_plant_gain  <= pwdata;
        pvaw_pkg::REG_OUTPUT_MAX:      cfg.output_max      <= pwdata[pvaw_pkg::DATA_W-2:0];
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      pvaw_pkg::REG_PROP_GAIN:       prdata = cfg.prop_gain;
      pvaw_pkg::REG_SETPOINT_WEIGHT: prdata = cfg.setpoint_weight;
      pvaw_pkg::REG_INTEGRAL_COEF:   prdata = cfg.integral_coef;
      pvaw_pkg::REG_DERIV_POLE:      prdata = cfg.deriv_pole;
      pvaw_pkg::REG_DERIV_GAIN:      prdata = cfg.deriv_gain;
      pvaw_pkg::REG_WINDUP_COEF:     prdata = cfg.windup_coef;
      pvaw_pkg::REG_INV_PLANT_GAIN:  prdata = cfg.inv_plant_gain;
      pvaw_pkg::REG_OUTPUT_MAX:      prdata = {1'b0, cfg.output_max};
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/pvaw_ctrl.sv]
// Sequencer: accepts a sample word, steps through the microcode, hands off the
// drive word to the output register. Depends on pvaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvaw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          sample_valid,
  output logic               sample_stall,
  input  wire logic          feedback_on,
  output logic               drive_valid,
  input  wire logic          drive_stall,
  output pvaw_pkg::dp_ctl_t  ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                        state;
  logic [pvaw_pkg::STEP_W-1:0]   step;
  logic                          fb_q;
  logic                          out_valid;
  logic                          out_free;
  logic                          accept;
  pvaw_pkg::cmd_t                cmd;

  assign cmd          = pvaw_pkg::ucode(fb_q, step);
  assign out_free     = !out_valid || !drive_stall;
  assign sample_stall = (state != S_IDLE);
  assign accept       = sample_valid && (state == S_IDLE);
  assign drive_valid  = out_valid;

  // last step waits for room in the output register
  assign ctl.cmd     = cmd;
  assign ctl.load_in = accept;
  assign ctl.exec    = (state == S_RUN) && (!cmd.last || out_free);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      fb_q  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            fb_q  <= feedback_on;
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (ctl.exec) begin
            if (cmd.last) begin
              state <= S_IDLE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.exec && cmd.last) begin
      out_valid <= 1'b1;
    end else if (!drive_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[sv/pvaw_dp.sv]
// Datapath: controller state, one shared 32x32 multiplier with a rounding stage,
// one saturating adder, the clamp and the output register. Depends on pvaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvaw_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pvaw_pkg::dp_ctl_t          ctl,
  input  wire pvaw_pkg::cfg_t             cfg,
  input  wire logic signed [pvaw_pkg::DATA_W-1:0] reference,
  input  wire logic signed [pvaw_pkg::DATA_W-1:0] measured,
  input  wire logic signed [pvaw_pkg::DATA_W-1:0] disturbance,
  input  wire logic                       feedback_on,
  input  wire logic                       antiwindup_on,
  output logic signed [pvaw_pkg::DATA_W-1:0]      drive
);

  localparam int W = pvaw_pkg::DATA_W;

  // controller state
  pvaw_pkg::word_t meas_now, meas_prev, prop_prev, integ_prev, integ_now;
  pvaw_pkg::word_t deriv_prev, ctrl_prev, clamp_error;
  // sample and working registers
  pvaw_pkg::word_t ref_q, dist_q, acc, tmp, aux, p1, d1, u1, vres, fm;
  logic            aw_q;
  logic signed [pvaw_pkg::PROD_W-1:0] prod;
  logic            prod_neg;

  pvaw_pkg::srcs_t srcs;
  pvaw_pkg::cmd_t  cmd;
  pvaw_pkg::word_t mul_a, mul_b, alu_a, alu_b, alu_res;
  logic signed [W:0] alu_sum;
  pvaw_pkg::word_t omax_w, clamp_v, clamp_e;
  logic signed [W:0] over_diff, neg_v;
  logic            wr;

  assign cmd = ctl.cmd;
  assign wr  = ctl.exec;

  always_comb begin
    srcs.fm      = fm;
    srcs.acc     = acc;
    srcs.tmp     = tmp;
    srcs.aux     = aux;
    srcs.refv    = ref_q;
    srcs.disturb = dist_q;
    srcs.mnow    = meas_now;
    srcs.mprev   = meas_prev;
    srcs.pprev   = prop_prev;
    srcs.inow    = integ_now;
    srcs.iprev   = integ_prev;
    srcs.dprev   = deriv_prev;
    srcs.uprev   = ctrl_prev;
    srcs.clamp   = clamp_error;
    srcs.d1      = d1;
    srcs.u1      = u1;
  end

  // operand selection
  assign mul_a = pvaw_pkg::pick_coef(cmd.mul_coef, cfg);
  assign mul_b = pvaw_pkg::pick(cmd.mul_src, srcs);
  assign alu_a = pvaw_pkg::pick(cmd.alu_a, srcs);
  assign alu_b = pvaw_pkg::pick(cmd.alu_b, srcs);

  // saturating add / subtract
  assign alu_sum = cmd.alu_sub ? ({alu_a[W-1], alu_a} - {alu_b[W-1], alu_b})
                               : ({alu_a[W-1], alu_a} + {alu_b[W-1], alu_b});
  assign alu_res = pvaw_pkg::sat_wide(alu_sum);

  // anti-windup clamp on the scaled drive
  assign omax_w    = {1'b0, cfg.output_max};
  assign over_diff = {omax_w[W-1], omax_w} - {fm[W-1], fm};
  assign neg_v     = -{fm[W-1], fm};
  always_comb begin
    if (aw_q && (fm > omax_w)) begin
      clamp_v = omax_w;
      clamp_e = pvaw_pkg::sat_wide(over_diff);
    end else if (aw_q && fm[W-1]) begin
      clamp_v = '0;
      clamp_e = pvaw_pkg::sat_wide(neg_v);
    end else begin
      clamp_v = fm;
      clamp_e = '0;
    end
  end

  // multiplier, then rounding stage
  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    prod_neg <= mul_a[W-1] ^ mul_b[W-1];
    fm       <= pvaw_pkg::fmul_fin(prod, prod_neg);
  end

  // sample capture and working registers
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      ref_q  <= reference;
      dist_q <= disturbance;
      aw_q   <= antiwindup_on;
    end
    if (wr) begin
      case (cmd.alu_dst)
        pvaw_pkg::DST_ACC: acc <= alu_res;
        pvaw_pkg::DST_TMP: tmp <= alu_res;
        pvaw_pkg::DST_AUX: aux <= alu_res;
        pvaw_pkg::DST_D1:  d1  <= alu_res;
        pvaw_pkg::DST_U1:  u1  <= alu_res;
        default: begin
        end
      endcase
      if (cmd.cap_p1) begin
        p1 <= fm;
      end
      if (cmd.clamp) begin
        vres <= clamp_v;
      end else if (cmd.take_v) begin
        vres <= fm;
      end
      if (cmd.last) begin
        drive <= vres;
      end
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_now    <= '0;
      meas_prev   <= '0;
      prop_prev   <= '0;
      integ_prev  <= '0;
      integ_now   <= '0;
      deriv_prev  <= '0;
      ctrl_prev   <= '0;
      clamp_error <= '0;
    end else begin
      if (ctl.load_in && feedback_on) begin
        meas_now <= measured;
      end
      if (wr) begin
        if (cmd.clamp) begin
          clamp_error <= clamp_e;
        end
        if (cmd.alu_dst == pvaw_pkg::DST_INTEG) begin
          integ_prev <= integ_now;
          integ_now  <= alu_res;
          meas_prev  <= meas_now;
        end
        if (cmd.commit_fb) begin
          prop_prev  <= p1;
          deriv_prev <= d1;
          ctrl_prev  <= u1;
        end
      end
    end
  end

endmodule

`default_nettype wire
